// ===== src/rollback_bipartite_union_find_assert.svh =====
// assertion macros for the rollback bipartite union-find block
// no dependencies; included by the modules that carry assertions
`ifndef ROLLBACK_BIPARTITE_UNION_FIND_ASSERT_SVH
`define ROLLBACK_BIPARTITE_UNION_FIND_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RBUF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define RBUF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/rbuf_pkg.sv =====
// shared constants and types for the rollback bipartite union-find block
// no dependencies
package rbuf_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int NODE_COUNT   = 2 * MAX_VERTICES;
    localparam int NODE_W       = $clog2(NODE_COUNT);
    localparam int VTX_W        = 11;
    localparam int DEPTH_W      = 12;
    localparam int RANK_W       = 4;

    localparam logic [VTX_W-1:0] VCOUNT_RESET = VTX_W'(MAX_VERTICES);
    localparam logic [VTX_W-1:0] VCOUNT_MAX   = VTX_W'(MAX_VERTICES);

    localparam logic CMD_ADD_EDGE = 1'b0;
    localparam logic CMD_ROLLBACK = 1'b1;

    // one forest entry: rank and parent pointer
    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [NODE_W-1:0] parent;
    } t_node;

    // one undo entry: linked root and rank-grew flag
    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic              grew;
    } t_undo;

endpackage

// ===== src/rollback_bipartite_union_find.sv =====
// top level of the rollback bipartite union-find block
// depends on rbuf_pkg, rbuf_ram and rollback_bipartite_union_find_assert.svh
//
// usage
//   command channel: an item is taken at a rising edge with start high and busy low.
//   i_cmd add edge: finds the roots of both endpoints; equal roots report a conflict,
//   otherwise each endpoint's mirror is joined with the other endpoint's set.
//   i_cmd rollback: pops undo entries until the stack depth equals i_version;
//   a version at or above the current depth changes nothing.
//   result: o_done is high for exactly one cycle with o_conflict and o_stack_depth;
//   the receiver cannot stall, so the result is gone after that cycle.
//   config: i_cfg_we writes vertex_count (clamped to 1..1024); the user must do so
//   only while idle, which the block does not enforce.
//   add edge: six root walks of up to 11 hops each on the single forest read port,
//   plus a write per link made and one more for a rank bump; an odd cycle ends
//   after the two endpoint walks, and an out of range item skips the walks.
//   rollback, per popped entry: read undo entry, read linked node, read its parent,
//   restore, drop rank. one item at a time.
// reset
//   i_rst_n is synchronous, active low. after reset a clearing pass writes all 2048
//   forest entries back to their own index with rank zero; busy is high.
module rollback_bipartite_union_find (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_cmd,
    input  logic [rbuf_pkg::VTX_W-1:0]  i_vertex_a,
    input  logic [rbuf_pkg::VTX_W-1:0]  i_vertex_b,
    input  logic [rbuf_pkg::DEPTH_W-1:0] i_version,
    input  logic                        i_cfg_we,
    input  logic [rbuf_pkg::VTX_W-1:0]  i_cfg_data,
    output logic                        o_done,
    output logic                        o_conflict,
    output logic [rbuf_pkg::DEPTH_W-1:0] o_stack_depth
);

`include "rollback_bipartite_union_find_assert.svh"

    localparam int NW = rbuf_pkg::NODE_W;
    localparam int DW = rbuf_pkg::DEPTH_W;
    localparam int RW = rbuf_pkg::RANK_W;
    localparam int VW = rbuf_pkg::VTX_W;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ISSUE,
        S_WALK,
        S_LINK,
        S_LINK2,
        S_POP_CHK,
        S_POP_RD,
        S_POP_Y,
        S_POP_W,
        S_POP_W2
    } t_state;

    // which root walk is running
    typedef enum logic [1:0] {
        T_A,
        T_B,
        T_P,
        T_Q
    } t_tag;

    t_state r_state, n_state;
    t_tag   r_tag, n_tag;

    logic [NW-1:0] r_clr, n_clr;
    logic [NW-1:0] r_cur, n_cur;
    logic [VW-1:0] r_vcount;
    logic [DW-1:0] r_depth, n_depth;
    logic [DW-1:0] r_version, n_version;
    logic [NW-1:0] r_b, n_b;
    logic [NW-1:0] r_an, n_an;
    logic [NW-1:0] r_bn, n_bn;
    logic [NW-1:0] r_ra, n_ra;
    logic [NW-1:0] r_rb, n_rb;
    logic          r_second, n_second;
    logic [NW-1:0] r_px, n_px;
    logic [RW-1:0] r_pxr, n_pxr;
    logic [NW-1:0] r_qy, n_qy;
    logic [RW-1:0] r_qyr, n_qyr;
    logic [NW-1:0] r_ypar, n_ypar;
    logic          r_grew, n_grew;
    logic          r_done, n_done;
    logic          r_conflict, n_conflict;
    logic [DW-1:0] r_out_depth, n_out_depth;

    // forest and undo stack ports
    logic            node_we;
    logic [NW-1:0]   node_wa;
    rbuf_pkg::t_node node_wd;
    logic [NW-1:0]   node_ra;
    rbuf_pkg::t_node node_rd;
    logic            stk_we;
    logic [NW-1:0]   stk_wa;
    rbuf_pkg::t_undo stk_wd;
    logic [NW-1:0]   stk_ra;
    rbuf_pkg::t_undo stk_rd;

    logic [VW-1:0] w_n;
    logic [NW-1:0] w_a;
    logic [NW-1:0] w_bz;
    logic          w_in_range;
    logic          w_link_fin;
    logic          w_swap;
    logic          w_rank_eq;

    // active vertex count, clamped to 1..MAX_VERTICES
    always_comb begin
        if (r_vcount == '0) begin
            w_n = VW'(1);
        end else if (r_vcount > rbuf_pkg::VCOUNT_MAX) begin
            w_n = rbuf_pkg::VCOUNT_MAX;
        end else begin
            w_n = r_vcount;
        end
    end

    assign w_in_range = (i_vertex_a != '0) && (i_vertex_a <= w_n)
                     && (i_vertex_b != '0) && (i_vertex_b <= w_n);
    assign w_a  = NW'(i_vertex_a - VW'(1));
    assign w_bz = NW'(i_vertex_b - VW'(1));

    // link ordering: the lower-rank root goes below
    assign w_swap    = (r_pxr > r_qyr);
    assign w_rank_eq = (r_pxr == r_qyr);

    always_comb begin
        n_state     = r_state;
        n_tag       = r_tag;
        n_clr       = r_clr;
        n_cur       = r_cur;
        n_depth     = r_depth;
        n_version   = r_version;
        n_b         = r_b;
        n_an        = r_an;
        n_bn        = r_bn;
        n_ra        = r_ra;
        n_rb        = r_rb;
        n_second    = r_second;
        n_px        = r_px;
        n_pxr       = r_pxr;
        n_qy        = r_qy;
        n_qyr       = r_qyr;
        n_ypar      = r_ypar;
        n_grew      = r_grew;
        n_done      = 1'b0;
        n_conflict  = 1'b0;
        n_out_depth = r_out_depth;
        node_we     = 1'b0;
        node_wa     = r_cur;
        node_wd     = '0;
        node_ra     = r_cur;
        stk_we      = 1'b0;
        stk_wa      = r_depth[NW-1:0];
        stk_wd      = '0;
        stk_ra      = NW'(r_depth - DW'(1));
        w_link_fin  = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                node_we        = 1'b1;
                node_wa        = r_clr;
                node_wd.rank   = '0;
                node_wd.parent = r_clr;
                n_clr          = r_clr + NW'(1);
                if (&r_clr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    if (i_cmd == rbuf_pkg::CMD_ROLLBACK) begin
                        n_version = i_version;
                        n_state   = S_POP_CHK;
                    end else if (w_in_range) begin
                        n_cur    = w_a;
                        n_b      = w_bz;
                        n_an     = w_a + NW'(w_n);
                        n_bn     = w_bz + NW'(w_n);
                        n_second = 1'b0;
                        n_tag    = T_A;
                        n_state  = S_ISSUE;
                    end else begin
                        // endpoint out of range: item ignored
                        n_done      = 1'b1;
                        n_out_depth = r_depth;
                    end
                end
            end
            S_ISSUE: begin
                n_state = S_WALK;
            end
            S_WALK: begin
                if (node_rd.parent != r_cur) begin
                    // follow the pointer, next read issued right away
                    n_cur   = node_rd.parent;
                    node_ra = node_rd.parent;
                end else begin
                    unique case (r_tag)
                        T_A: begin
                            n_ra    = r_cur;
                            n_cur   = r_b;
                            n_tag   = T_B;
                            n_state = S_ISSUE;
                        end
                        T_B: begin
                            n_rb = r_cur;
                            if (r_ra == r_cur) begin
                                // odd cycle: report and change nothing
                                n_done      = 1'b1;
                                n_conflict  = 1'b1;
                                n_out_depth = r_depth;
                                n_state     = S_IDLE;
                            end else begin
                                n_cur   = r_an;
                                n_tag   = T_P;
                                n_state = S_ISSUE;
                            end
                        end
                        T_P: begin
                            n_px    = r_cur;
                            n_pxr   = node_rd.rank;
                            n_cur   = r_second ? r_ra : r_rb;
                            n_tag   = T_Q;
                            n_state = S_ISSUE;
                        end
                        T_Q: begin
                            n_qy    = r_cur;
                            n_qyr   = node_rd.rank;
                            n_state = S_LINK;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_LINK: begin
                if ((r_px == r_qy) || r_depth[DW-1]) begin
                    // same set, or stack full
                    w_link_fin = 1'b1;
                end else begin
                    node_we        = 1'b1;
                    node_wa        = w_swap ? r_qy : r_px;
                    node_wd.rank   = w_swap ? r_qyr : r_pxr;
                    node_wd.parent = w_swap ? r_px : r_qy;
                    stk_we         = 1'b1;
                    stk_wd.node    = w_swap ? r_qy : r_px;
                    stk_wd.grew    = w_rank_eq;
                    n_depth        = r_depth + DW'(1);
                    // keep the new parent for the rank bump
                    n_qy           = w_swap ? r_px : r_qy;
                    n_qyr          = w_swap ? r_pxr : r_qyr;
                    if (w_rank_eq) begin
                        n_state = S_LINK2;
                    end else begin
                        w_link_fin = 1'b1;
                    end
                end
            end
            S_LINK2: begin
                node_we        = 1'b1;
                node_wa        = r_qy;
                node_wd.rank   = r_qyr + RW'(1);
                node_wd.parent = r_qy;
                w_link_fin     = 1'b1;
            end
            S_POP_CHK: begin
                if (r_depth > r_version) begin
                    n_depth = r_depth - DW'(1);
                    n_state = S_POP_RD;
                end else begin
                    n_done      = 1'b1;
                    n_out_depth = r_depth;
                    n_state     = S_IDLE;
                end
            end
            S_POP_RD: begin
                n_cur   = stk_rd.node;
                n_grew  = stk_rd.grew;
                node_ra = stk_rd.node;
                n_state = S_POP_Y;
            end
            S_POP_Y: begin
                n_pxr   = node_rd.rank;
                n_qy    = node_rd.parent;
                node_ra = node_rd.parent;
                n_state = S_POP_W;
            end
            S_POP_W: begin
                // detach the linked root
                node_we        = 1'b1;
                node_wa        = r_cur;
                node_wd.rank   = r_pxr;
                node_wd.parent = r_cur;
                n_qyr          = node_rd.rank;
                n_ypar         = node_rd.parent;
                if (r_grew && (node_rd.rank != '0)) begin
                    n_state = S_POP_W2;
                end else begin
                    n_state = S_POP_CHK;
                end
            end
            S_POP_W2: begin
                node_we        = 1'b1;
                node_wa        = r_qy;
                node_wd.rank   = r_qyr - RW'(1);
                node_wd.parent = r_ypar;
                n_state        = S_POP_CHK;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // after a link: second join, or finish the item
        if (w_link_fin) begin
            if (!r_second) begin
                n_second = 1'b1;
                n_cur    = r_bn;
                n_tag    = T_P;
                n_state  = S_ISSUE;
            end else begin
                n_done      = 1'b1;
                n_out_depth = n_depth;
                n_state     = S_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr      <= '0;
            r_depth    <= '0;
            r_vcount   <= rbuf_pkg::VCOUNT_RESET;
            r_done     <= 1'b0;
            r_conflict <= 1'b0;
            r_second   <= 1'b0;
            r_tag      <= T_A;
        end else begin
            r_state    <= n_state;
            r_clr      <= n_clr;
            r_depth    <= n_depth;
            r_done     <= n_done;
            r_conflict <= n_conflict;
            r_second   <= n_second;
            r_tag      <= n_tag;
            if (i_cfg_we) begin
                r_vcount <= i_cfg_data;
            end
        end
        r_cur       <= n_cur;
        r_version   <= n_version;
        r_b         <= n_b;
        r_an        <= n_an;
        r_bn        <= n_bn;
        r_ra        <= n_ra;
        r_rb        <= n_rb;
        r_px        <= n_px;
        r_pxr       <= n_pxr;
        r_qy        <= n_qy;
        r_qyr       <= n_qyr;
        r_ypar      <= n_ypar;
        r_grew      <= n_grew;
        r_out_depth <= n_out_depth;
    end

    // forest: rank and parent per node
    rbuf_ram #(
        .WIDTH ($bits(rbuf_pkg::t_node)),
        .DEPTH (rbuf_pkg::NODE_COUNT)
    ) u_forest (
        .i_clk     (i_clk),
        .i_we      (node_we),
        .i_wr_addr (node_wa),
        .i_wr_data (node_wd),
        .i_rd_addr (node_ra),
        .o_rd_data (node_rd)
    );

    // undo stack, contents undefined until pushed
    rbuf_ram #(
        .WIDTH ($bits(rbuf_pkg::t_undo)),
        .DEPTH (rbuf_pkg::NODE_COUNT)
    ) u_undo (
        .i_clk     (i_clk),
        .i_we      (stk_we),
        .i_wr_addr (stk_wa),
        .i_wr_data (stk_wd),
        .i_rd_addr (stk_ra),
        .o_rd_data (stk_rd)
    );

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_conflict    = r_conflict;
    assign o_stack_depth = r_out_depth;

    `RBUF_ASSERT_NEXT(a_accept_leads_on, i_clk, i_rst_n, start && !busy, busy || o_done, "accepted item neither busy nor done")
    `RBUF_ASSERT_NOW(a_done_when_idle, i_clk, i_rst_n, o_done, !busy, "result strobe while busy")
    `RBUF_ASSERT_NOW(a_conflict_strobed, i_clk, i_rst_n, o_conflict, o_done, "conflict without result strobe")
    `RBUF_ASSERT_NOW(a_depth_step, i_clk, i_rst_n, r_depth != $past(r_depth), (r_depth == $past(r_depth) + DW'(1)) || (r_depth == $past(r_depth) - DW'(1)), "stack depth jumped")
    `RBUF_ASSERT_NOW(a_pop_floor, i_clk, i_rst_n, r_state == S_POP_RD, r_depth >= r_version, "rollback popped below version")

endmodule

// ===== src/rbuf_ram.sv =====
// simple dual-port ram, one write port and one registered read port
// no dependencies
module rbuf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== verif/tb.sv =====
// self-checking testbench for rollback_bipartite_union_find: directed probes, then random edges
// and rollbacks across several vertex counts, each result checked against a hand value or forest predictor
// depends on rbuf_pkg and the rollback_bipartite_union_find rtl
`timescale 1ns / 1ps

module tb;

    localparam int     HALF_PERIOD  = 4;
    localparam int     PHASE_ITEMS  = 232;
    localparam int     DRAIN_CYCLES = 100;
    localparam int     RING_DEPTH   = 4;
    localparam longint LIMIT_NS     = 10_000_000;

    // directed probes either carry a result worked out by hand or defer to the predictor
    localparam bit BY_HAND  = 1'b1;
    localparam bit BY_MODEL = 1'b0;

    // one result as the block reports it
    typedef struct packed {
        logic                         conflict;
        logic [rbuf_pkg::DEPTH_W-1:0] depth;
    } t_verdict;

    // one directed item
    typedef struct packed {
        logic                         cmd;
        logic [rbuf_pkg::VTX_W-1:0]   vertex_a;
        logic [rbuf_pkg::VTX_W-1:0]   vertex_b;
        logic [rbuf_pkg::DEPTH_W-1:0] version;
        bit                           by_hand;
        t_verdict                     outcome;
    } t_probe;

    localparam int PROBE_COUNT = 23;
    localparam t_probe PROBES [PROBE_COUNT] = '{
        // self loop on a fresh forest closes an odd cycle
        '{rbuf_pkg::CMD_ADD_EDGE, 11'd1,    11'd1,    12'd0,    BY_HAND,  '{1'b1, 12'd0}},
        // endpoints out of range are ignored
        '{rbuf_pkg::CMD_ADD_EDGE, 11'd0,    11'd5,    12'd0,    BY_HAND,  '{1'b0, 12'd0}},
        '{rbuf_pkg::CMD_ADD_EDGE, 11'd1025, 11'd5,    12'd4095, BY_HAND,  '{1'b0, 12'd0}},
        '{rbuf_pkg::CMD_ADD_EDGE, 11'd5,    11'd2047, 12'd0,    BY_HAND,  '{1'b0, 12'd0}},
        // rollback on an empty stack
        '{rbuf_pkg::CMD_ROLLBACK, 11'd2047, 11'd2047, 12'd0,    BY_HAND,  '{1'b0, 12'd0}},
        // first real edge pushes two links
        '{rbuf_pkg::CMD_ADD_EDGE, 11'd1,    11'd2,    12'd0,    BY_HAND,  '{1'b0, 12'd2}},
        '{rbuf_pkg::CMD_ADD_EDGE, 11'd2,    11'd3,    12'd0,    BY_MODEL, '0},
        // triangle 1-2-3 is odd
        '{rbuf_pkg::CMD_ADD_EDGE, 11'd1,    11'd3,    12'd0,    BY_MODEL, '0},
        '{rbuf_pkg::CMD_ADD_EDGE, 11'd3,    11'd4,    12'd0,    BY_MODEL, '0},
        // square 1-2-3-4 is even, sets already joined
        '{rbuf_pkg::CMD_ADD_EDGE, 11'd1,    11'd4,    12'd0,    BY_MODEL, '0},
        '{rbuf_pkg::CMD_ADD_EDGE, 11'd1024, 11'd1023, 12'd0,    BY_MODEL, '0},
        '{rbuf_pkg::CMD_ADD_EDGE, 11'd1023, 11'd1,    12'd0,    BY_MODEL, '0},
        '{rbuf_pkg::CMD_ADD_EDGE, 11'd1024, 11'd1,    12'd0,    BY_MODEL, '0},
        // version far above depth changes nothing
        '{rbuf_pkg::CMD_ROLLBACK, 11'd0,    11'd0,    12'd4095, BY_MODEL, '0},
        '{rbuf_pkg::CMD_ROLLBACK, 11'd0,    11'd0,    12'd3,    BY_MODEL, '0},
        '{rbuf_pkg::CMD_ROLLBACK, 11'd0,    11'd0,    12'd2,    BY_MODEL, '0},
        // odd triangle edge is legal again once 2-3 is undone
        '{rbuf_pkg::CMD_ADD_EDGE, 11'd1,    11'd3,    12'd0,    BY_MODEL, '0},
        '{rbuf_pkg::CMD_ROLLBACK, 11'd1365, 11'd682,  12'd0,    BY_HAND,  '{1'b0, 12'd0}},
        '{rbuf_pkg::CMD_ADD_EDGE, 11'd1024, 11'd1024, 12'd0,    BY_HAND,  '{1'b1, 12'd0}},
        '{rbuf_pkg::CMD_ADD_EDGE, 11'd1024, 11'd1,    12'd2730, BY_HAND,  '{1'b0, 12'd2}},
        // partial rollback pops a single link
        '{rbuf_pkg::CMD_ROLLBACK, 11'd0,    11'd0,    12'd1,    BY_HAND,  '{1'b0, 12'd1}},
        '{rbuf_pkg::CMD_ADD_EDGE, 11'd6,    11'd7,    12'd0,    BY_MODEL, '0},
        '{rbuf_pkg::CMD_ROLLBACK, 11'd0,    11'd0,    12'd2048, BY_MODEL, '0}
    };

    // vertex counts for the random phases: clamped low and high, exact extremes, odd sizes
    localparam int PHASE_COUNT = 8;
    localparam logic [rbuf_pkg::VTX_W-1:0] VCOUNT_PLAN [PHASE_COUNT] = '{
        11'd0, 11'd3, 11'd2047, 11'd1, 11'd40, 11'd1025, 11'd12, 11'd1024
    };

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    logic                         i_cmd;
    logic [rbuf_pkg::VTX_W-1:0]   i_vertex_a;
    logic [rbuf_pkg::VTX_W-1:0]   i_vertex_b;
    logic [rbuf_pkg::DEPTH_W-1:0] i_version;
    logic                         i_cfg_we;
    logic [rbuf_pkg::VTX_W-1:0]   i_cfg_data;
    logic                         o_done;
    logic                         o_conflict;
    logic [rbuf_pkg::DEPTH_W-1:0] o_stack_depth;

    rollback_bipartite_union_find dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_vertex_a    (i_vertex_a),
        .i_vertex_b    (i_vertex_b),
        .i_version     (i_version),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .o_done        (o_done),
        .o_conflict    (o_conflict),
        .o_stack_depth (o_stack_depth)
    );

    always begin
        #(HALF_PERIOD) i_clk = 1'b1;
        #(HALF_PERIOD) i_clk = 1'b0;
    end

    // predictor copy of the forest, the undo log and the vertex count register
    int unsigned                forest_parent [rbuf_pkg::NODE_COUNT];
    int unsigned                forest_rank   [rbuf_pkg::NODE_COUNT];
    rbuf_pkg::t_undo            link_log      [rbuf_pkg::NODE_COUNT];
    int unsigned                link_depth;
    logic [rbuf_pkg::VTX_W-1:0] vcount_reg;

    // outstanding results, oldest at the read pointer
    t_verdict    pending_verdicts [RING_DEPTH];
    int unsigned ring_wr = 0;
    int unsigned ring_rd = 0;
    t_verdict    head_verdict;
    int          fault_count;
    bit          steady;

    // register value as the block uses it, clamped to 1..MAX_VERTICES
    function automatic int unsigned vertex_limit();
        if (vcount_reg == '0) begin
            return 1;
        end
        if (vcount_reg > rbuf_pkg::MAX_VERTICES) begin
            return rbuf_pkg::MAX_VERTICES;
        end
        return 32'(vcount_reg);
    endfunction

    // plain walk to the root, no path compression
    function automatic int unsigned forest_root(int unsigned node);
        int unsigned x;
        x = node % rbuf_pkg::NODE_COUNT;
        while (forest_parent[x] != x) begin
            x = forest_parent[x] % rbuf_pkg::NODE_COUNT;
        end
        return x;
    endfunction

    // union by rank; the lower root goes under the other and its link is logged
    function automatic void forest_link(int unsigned p, int unsigned q);
        int unsigned x;
        int unsigned y;
        int unsigned t;
        bit          grew;
        x = forest_root(p);
        y = forest_root(q);
        if (x == y || link_depth >= rbuf_pkg::NODE_COUNT) begin
            return;
        end
        if (forest_rank[x] > forest_rank[y]) begin
            t = x;
            x = y;
            y = t;
        end
        grew = (forest_rank[x] == forest_rank[y]);
        link_log[link_depth] = '{node: rbuf_pkg::NODE_W'(x), grew: grew};
        link_depth++;
        forest_parent[x] = y;
        if (grew && forest_rank[y] < 255) begin
            forest_rank[y]++;
        end
    endfunction

    // undo logged links, newest first, down to the target depth
    function automatic void forest_rewind(int unsigned target);
        rbuf_pkg::t_undo entry;
        int unsigned     x;
        int unsigned     y;
        while (link_depth > target) begin
            link_depth--;
            entry = link_log[link_depth % rbuf_pkg::NODE_COUNT];
            x = 32'(entry.node);
            y = forest_parent[x] % rbuf_pkg::NODE_COUNT;
            if (entry.grew && forest_rank[y] > 0) begin
                forest_rank[y]--;
            end
            forest_parent[x] = x;
        end
    endfunction

    // applies one item to the predictor and returns the result it should give
    function automatic t_verdict predict_verdict(logic cmd, logic [rbuf_pkg::VTX_W-1:0] va,
                                                 logic [rbuf_pkg::VTX_W-1:0] vb,
                                                 logic [rbuf_pkg::DEPTH_W-1:0] ver);
        t_verdict    v;
        int unsigned n;
        int unsigned ra;
        int unsigned rb;
        v.conflict = 1'b0;
        n = vertex_limit();
        if (cmd == rbuf_pkg::CMD_ROLLBACK) begin
            forest_rewind(32'(ver));
        end else if (va >= 1 && va <= n && vb >= 1 && vb <= n) begin
            ra = forest_root(32'(va) - 1);
            rb = forest_root(32'(vb) - 1);
            if (ra == rb) begin
                // both ends on the same side: odd cycle
                v.conflict = 1'b1;
            end else begin
                // each endpoint's mirror joins the other endpoint's set
                forest_link(32'(va) - 1 + n, rb);
                forest_link(32'(vb) - 1 + n, ra);
            end
        end
        v.depth = rbuf_pkg::DEPTH_W'(link_depth);
        return v;
    endfunction

    // presents one item from a falling edge, holds it until taken, records its result;
    // returns at the falling edge after acceptance with start still high
    task automatic issue_item(input logic cmd, input logic [rbuf_pkg::VTX_W-1:0] va,
                              input logic [rbuf_pkg::VTX_W-1:0] vb,
                              input logic [rbuf_pkg::DEPTH_W-1:0] ver,
                              input bit by_hand, input t_verdict hand_verdict);
        t_verdict predicted;
        // random sender gaps, skipped during the steady stretch
        while (!steady && $urandom_range(0, 99) < 26) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start      <= 1'b1;
        i_cmd      <= cmd;
        i_vertex_a <= va;
        i_vertex_b <= vb;
        i_version  <= ver;
        do begin
            @(posedge i_clk);
        end while (busy);
        predicted = predict_verdict(cmd, va, vb, ver);
        pending_verdicts[ring_wr % RING_DEPTH] = by_hand ? hand_verdict : predicted;
        ring_wr++;
        @(negedge i_clk);
    endtask

    // result checker: every strobe must match the oldest outstanding item
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (ring_wr == ring_rd) begin
                $error("result with no item outstanding: conflict %0d stack_depth %0d",
                       o_conflict, o_stack_depth);
                fault_count++;
            end else begin
                head_verdict = pending_verdicts[ring_rd % RING_DEPTH];
                ring_rd++;
                if (o_conflict !== head_verdict.conflict) begin
                    $error("conflict mismatch: expected %0d actual %0d",
                           head_verdict.conflict, o_conflict);
                    fault_count++;
                end
                if (o_stack_depth !== head_verdict.depth) begin
                    $error("stack_depth mismatch: expected %0d actual %0d",
                           head_verdict.depth, o_stack_depth);
                    fault_count++;
                end
            end
        end
    end

    // hard stop in case the block hangs
    initial begin
        #(LIMIT_NS);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int unsigned                  n;
        int unsigned                  span;
        int unsigned                  hi;
        int unsigned                  roll;
        int unsigned                  random_issued;
        logic                         cmd;
        logic [rbuf_pkg::VTX_W-1:0]   va;
        logic [rbuf_pkg::VTX_W-1:0]   vb;
        logic [rbuf_pkg::DEPTH_W-1:0] ver;

        // every input known from time zero
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_cmd      = rbuf_pkg::CMD_ADD_EDGE;
        i_vertex_a = '0;
        i_vertex_b = '0;
        i_version  = '0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        fault_count   = 0;
        steady        = 1'b0;
        random_issued = 0;

        // predictor reset state
        for (int i = 0; i < rbuf_pkg::NODE_COUNT; i++) begin
            forest_parent[i] = unsigned'(i);
            forest_rank[i]   = 0;
        end
        link_depth = 0;
        vcount_reg = rbuf_pkg::VCOUNT_RESET;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // let the clearing pass get going, then wait it out
        repeat (2) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);

        // directed probes at the reset vertex count
        for (int k = 0; k < PROBE_COUNT; k++) begin
            issue_item(PROBES[k].cmd, PROBES[k].vertex_a, PROBES[k].vertex_b,
                       PROBES[k].version, PROBES[k].by_hand, PROBES[k].outcome);
        end

        // random phases, one vertex count each; the forest carries over between them
        for (int p = 0; p < PHASE_COUNT; p++) begin
            // drain and go idle before touching the register
            start <= 1'b0;
            while (ring_wr != ring_rd || busy) @(posedge i_clk);
            @(negedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_data <= VCOUNT_PLAN[p];
            vcount_reg = VCOUNT_PLAN[p];
            @(negedge i_clk);
            i_cfg_we <= 1'b0;

            n = vertex_limit();
            // a narrow vertex pool makes cycles, odd and even, much more likely
            span = (n <= 24) ? n : $urandom_range(10, 48);

            repeat (PHASE_ITEMS) begin
                // one long stretch with no sender gaps
                steady = (random_issued >= 600 && random_issued < 900);
                roll = $urandom_range(0, 99);
                va   = rbuf_pkg::VTX_W'($urandom);
                vb   = rbuf_pkg::VTX_W'($urandom);
                ver  = rbuf_pkg::DEPTH_W'($urandom);
                if (roll < 8) begin
                    // noise: any command, any field value, mostly out of range
                    cmd = $urandom_range(0, 1) ? rbuf_pkg::CMD_ROLLBACK : rbuf_pkg::CMD_ADD_EDGE;
                end else if (roll < 22) begin
                    // rollback, usually to a version at or below the current depth
                    cmd = rbuf_pkg::CMD_ROLLBACK;
                    if ($urandom_range(0, 4) == 0) begin
                        ver = rbuf_pkg::DEPTH_W'($urandom_range(link_depth, 4095));
                    end else begin
                        ver = rbuf_pkg::DEPTH_W'($urandom_range(0, link_depth));
                    end
                end else begin
                    // edge, mostly inside the narrow pool; legal unless the pool runs past the vertex count
                    cmd = rbuf_pkg::CMD_ADD_EDGE;
                    hi  = ($urandom_range(0, 9) < 7) ? span : n;
                    va  = rbuf_pkg::VTX_W'($urandom_range(1, hi));
                    vb  = rbuf_pkg::VTX_W'($urandom_range(1, hi));
                end
                issue_item(cmd, va, vb, ver, BY_MODEL, '0);
                random_issued++;
            end
        end

        // wait for the last results, then let the clock run quiet before reporting
        start <= 1'b0;
        while (ring_wr != ring_rd) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fault_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== rollback_bipartite_union_find.f =====
+incdir+src
src/rbuf_pkg.sv
src/rbuf_ram.sv
src/rollback_bipartite_union_find.sv
verif/tb.sv
